// ----- design/rcph_pkg.sv -----
// Shared types and constants for the RC pulse to H-bridge drive block.
`default_nettype none
package rcph_pkg;

  localparam int unsigned OFS_W      = 12;
  localparam int unsigned CMD_W      = 14;
  localparam int unsigned DUTY_W     = 6;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CMD_W-1:0] CMD_MAX  = 14'd16383;
  localparam logic [CMD_W-1:0] BAND_LOW = 14'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_END     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_SLOW_FROM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_FROM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TO       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_SLOW_TO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TOP     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_ABOVE     = 3'd7;

  // Register reset values
  localparam logic [OFS_W-1:0]  RST_WIDTH_OFFSET  = 12'd250;
  localparam logic [CMD_W-1:0]  RST_VALID_END     = 14'd973;
  localparam logic [CMD_W-1:0]  RST_FWD_SLOW_FROM = 14'd250;
  localparam logic [CMD_W-1:0]  RST_LOCK_FROM     = 14'd450;
  localparam logic [CMD_W-1:0]  RST_LOCK_TO       = 14'd550;
  localparam logic [CMD_W-1:0]  RST_REV_SLOW_TO   = 14'd750;
  localparam logic [DUTY_W-1:0] RST_CYCLE_TOP     = 6'd40;
  localparam logic [DUTY_W-1:0] RST_OFF_ABOVE     = 6'd38;

  typedef struct packed {
    logic [OFS_W-1:0]  width_offset;
    logic [CMD_W-1:0]  valid_end;
    logic [CMD_W-1:0]  fwd_slow_from;
    logic [CMD_W-1:0]  lock_from;
    logic [CMD_W-1:0]  lock_to;
    logic [CMD_W-1:0]  rev_slow_to;
    logic [DUTY_W-1:0] cycle_top;
    logic [DUTY_W-1:0] off_above;
  } cfg_t;

endpackage
`default_nettype wire

// ----- design/rc_pulse_to_hbridge_drive.sv -----
// Path: an accepted sample updates the stage-one count, command and duty registers, and its
// drive pair is decoded from them into the output register. Throughput: one sample per cycle
// while the output is not stalled; stage two advances whenever the output slot is free.
// Back-pressure on the output stalls stage two; with stage one also full it drops in_ready_o.
// Reset: asynchronous, active low; counters and command clear, registers take their defaults.
`default_nettype none
module rc_pulse_to_hbridge_drive #(
  parameter int unsigned COUNT_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rcph_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [rcph_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               line_level_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    drive_a_o,
  output logic                                    drive_b_o
);
  import rcph_pkg::*;

  localparam int unsigned DW = (COUNT_BITS > OFS_W) ? COUNT_BITS : OFS_W;

  cfg_t                  cfg_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [DUTY_W-1:0]     duty_q, duty_d;
  logic                  s1_valid_q;
  logic                  out_valid_q;
  logic                  drive_a_q, drive_b_q;
  logic                  dec_a, dec_b;
  logic                  advance, accept;

  logic [DW-1:0]   cnt_ext, ofs_ext, diff;
  logic [DW+1:0]   prod;
  logic [CMD_W-1:0] cmd_new;
  logic [DUTY_W:0] duty_inc;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_offset  <= RST_WIDTH_OFFSET;
      cfg_q.valid_end     <= RST_VALID_END;
      cfg_q.fwd_slow_from <= RST_FWD_SLOW_FROM;
      cfg_q.lock_from     <= RST_LOCK_FROM;
      cfg_q.lock_to       <= RST_LOCK_TO;
      cfg_q.rev_slow_to   <= RST_REV_SLOW_TO;
      cfg_q.cycle_top     <= RST_CYCLE_TOP;
      cfg_q.off_above     <= RST_OFF_ABOVE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH_OFFSET:  cfg_q.width_offset  <= cfg_data_i[OFS_W-1:0];
        CFG_VALID_END:     cfg_q.valid_end     <= cfg_data_i[CMD_W-1:0];
        CFG_FWD_SLOW_FROM: cfg_q.fwd_slow_from <= cfg_data_i[CMD_W-1:0];
        CFG_LOCK_FROM:     cfg_q.lock_from     <= cfg_data_i[CMD_W-1:0];
        CFG_LOCK_TO:       cfg_q.lock_to       <= cfg_data_i[CMD_W-1:0];
        CFG_REV_SLOW_TO:   cfg_q.rev_slow_to   <= cfg_data_i[CMD_W-1:0];
        CFG_CYCLE_TOP:     cfg_q.cycle_top     <= cfg_data_i[DUTY_W-1:0];
        CFG_OFF_ABOVE:     cfg_q.off_above     <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Pulse width measurement, command scaling and duty stepping
  always_comb begin
    cnt_ext  = DW'(cnt_q);
    ofs_ext  = DW'(cfg_q.width_offset);
    diff     = cnt_ext - ofs_ext;
    prod     = {2'b00, diff} + {1'b0, diff, 1'b0};
    if (cnt_ext > ofs_ext) begin
      cmd_new = (prod > (DW + 2)'(CMD_MAX)) ? CMD_MAX : prod[CMD_W-1:0];
    end else begin
      cmd_new = '0;
    end
    duty_inc = {1'b0, duty_q} + {{DUTY_W{1'b0}}, 1'b1};

    cnt_d  = cnt_q;
    cmd_d  = cmd_q;
    duty_d = duty_q;
    if (line_level_i) begin
      if (!(&cnt_q)) begin
        cnt_d = cnt_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
    end else begin
      if (cnt_q != '0) begin
        cmd_d = cmd_new;
        cnt_d = '0;
      end
      // Wrap once past the top value
      if (duty_inc > {1'b0, cfg_q.cycle_top}) begin
        duty_d = '0;
      end else begin
        duty_d = duty_inc[DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cmd_q  <= '0;
      duty_q <= '0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      cmd_q  <= cmd_d;
      duty_q <= duty_d;
    end
  end

  rcph_decode u_decode (
    .cmd_i     (cmd_q),
    .duty_i    (duty_q),
    .cfg_i     (cfg_q),
    .drive_a_o (dec_a),
    .drive_b_o (dec_b)
  );

  // Stage valids: stage two advances whenever the output slot frees up, stage one when in_ready_o
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      drive_a_q <= dec_a;
      drive_b_q <= dec_b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_a_o   = drive_a_q;
  assign drive_b_o   = drive_b_q;

`ifndef ASSERT_OFF
  a_high_holds_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && line_level_i) |=> $stable(duty_q))
    else $error("duty counter moved on a high sample");

  a_high_no_decrease: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && line_level_i) |=> (cnt_q >= $past(cnt_q)))
    else $error("width counter fell during a pulse");

  a_low_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !line_level_i) |=> (cnt_q == '0))
    else $error("width counter not cleared on a low sample");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("request refused without a full pipeline");
`endif

endmodule
`default_nettype wire

// ----- design/rcph_decode.sv -----
// Bridge output decoder: command and duty position to drive pair.
`default_nettype none
module rcph_decode (
  input  wire logic [rcph_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [rcph_pkg::DUTY_W-1:0] duty_i,
  input  wire rcph_pkg::cfg_t              cfg_i,
  output logic                             drive_a_o,
  output logic                             drive_b_o
);
  import rcph_pkg::*;

  logic off;

  always_comb begin
    off       = duty_i > cfg_i.off_above;
    drive_a_o = 1'b0;
    drive_b_o = 1'b0;
    // Later bands override earlier ones when the limits are misordered
    if (cmd_i >= BAND_LOW && cmd_i < cfg_i.valid_end) begin
      if (cmd_i < cfg_i.fwd_slow_from) begin
        drive_a_o = 1'b0;
        drive_b_o = 1'b1;
      end
      if (cmd_i >= cfg_i.fwd_slow_from && cmd_i < cfg_i.lock_from) begin
        drive_a_o = 1'b0;
        drive_b_o = !off;
      end
      if (cmd_i >= cfg_i.lock_from && cmd_i < cfg_i.lock_to) begin
        drive_a_o = 1'b1;
        drive_b_o = 1'b1;
      end
      if (cmd_i >= cfg_i.lock_to && cmd_i < cfg_i.rev_slow_to) begin
        drive_a_o = !off;
        drive_b_o = 1'b0;
      end
      if (cmd_i >= cfg_i.rev_slow_to) begin
        drive_a_o = 1'b1;
        drive_b_o = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_rc_pulse_to_hbridge_drive.sv -----
// Self-checking bench for the RC pulse to H-bridge drive block: pulse trains in, drive pairs out.
`timescale 1ns / 100ps

module tb_rc_pulse_to_hbridge_drive;
  import rcph_pkg::*;

  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned DW         = CFG_DATA_W;
  localparam int unsigned CYCLE_CAP  = 600000;
  localparam int unsigned ITEM_TOTAL = 1650;

  typedef struct packed {
    logic a;
    logic b;
  } drive_pair_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DW-1:0]  cfg_data_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  logic           line_level_i = 1'b0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  logic           drive_a_o;
  logic           drive_b_o;

  rc_pulse_to_hbridge_drive #(
    .COUNT_BITS(COUNT_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .line_level_i(line_level_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_a_o   (drive_a_o),
    .drive_b_o   (drive_b_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state
  cfg_t              regs_q;
  logic [COUNT_W-1:0] width_cnt;
  logic [CMD_W-1:0]  cmd_q;
  logic [DUTY_W-1:0] duty_q;

  bit          sample_queue[$];
  drive_pair_t drive_due[$];
  int unsigned fault_count = 0;
  int unsigned cycle_cnt = 0;
  int          queued_total = 0;
  bit          want_hold = 1'b0;

  task automatic report_fault(input string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endtask

  function automatic drive_pair_t decode_drive();
    drive_pair_t d;
    bit          off;
    off = duty_q > regs_q.off_above;
    d   = '0;
    if (cmd_q >= BAND_LOW && cmd_q < regs_q.valid_end) begin
      // later bands override earlier ones when the registers overlap
      if (cmd_q < regs_q.fwd_slow_from) d = '{a: 1'b0, b: 1'b1};
      if (cmd_q >= regs_q.fwd_slow_from && cmd_q < regs_q.lock_from)
        d = '{a: 1'b0, b: !off};
      if (cmd_q >= regs_q.lock_from && cmd_q < regs_q.lock_to) d = '{a: 1'b1, b: 1'b1};
      if (cmd_q >= regs_q.lock_to && cmd_q < regs_q.rev_slow_to)
        d = '{a: !off, b: 1'b0};
      if (cmd_q >= regs_q.rev_slow_to) d = '{a: 1'b1, b: 1'b0};
    end
    return d;
  endfunction

  function automatic void predict_sample(input bit level);
    int unsigned scaled;
    int unsigned next_duty;
    if (level) begin
      if (width_cnt != '1) width_cnt++;
    end else begin
      if (width_cnt != '0) begin
        if (int'(width_cnt) > int'(regs_q.width_offset)) begin
          scaled = (int'(width_cnt) - int'(regs_q.width_offset)) * 3;
          cmd_q  = (scaled > CMD_MAX) ? CMD_MAX : scaled[CMD_W-1:0];
        end else begin
          cmd_q = '0;
        end
        width_cnt = '0;
      end
      next_duty = duty_q + 1;
      duty_q    = (next_duty > regs_q.cycle_top) ? '0 : next_duty[DUTY_W-1:0];
    end
    drive_due.push_back(decode_drive());
  endfunction

  // Sender: bursts of requests separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    bit offer;
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_sample(sample_queue.pop_front());
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_queue.size() > 0) begin
          offer = 1'b1;
          line_level_i <= sample_queue[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 64);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 2);
              2: gap_left = $urandom_range(1, 8);
              default: gap_left = $urandom_range(10, 30);
            endcase
          end
        end
      end
      in_valid_i <= offer;
    end
  end

  // Receiver: checks each drive pair, stalls on its own pattern
  logic [15:0] stall_pat = '1;
  int          rx_tick   = 0;
  int          hold_left = -1;

  always @(posedge clk_i) begin
    drive_pair_t got;
    bit          rdy;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{a: drive_a_o, b: drive_b_o};
        if (drive_due.size() == 0) begin
          report_fault($sformatf("unexpected drive pair a=%b b=%b", got.a, got.b));
        end else if (got !== drive_due[0]) begin
          report_fault($sformatf("drive mismatch: expected a=%b b=%b, got a=%b b=%b",
                                 drive_due[0].a, drive_due[0].b, got.a, got.b));
          void'(drive_due.pop_front());
        end else begin
          void'(drive_due.pop_front());
        end
      end
      rx_tick++;
      if (rx_tick % 32 == 0) begin
        // a quarter of the windows run with no stalls at all
        if ($urandom_range(0, 3) == 0) stall_pat = '1;
        else stall_pat = 16'($urandom() | $urandom());
      end
      if (want_hold && hold_left < 0) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = stall_pat[rx_tick[3:0]];
      end
      out_ready_i <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("rc_pulse_to_hbridge_drive test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WIDTH_OFFSET:  regs_q.width_offset  = val[OFS_W-1:0];
      CFG_VALID_END:     regs_q.valid_end     = val[CMD_W-1:0];
      CFG_FWD_SLOW_FROM: regs_q.fwd_slow_from = val[CMD_W-1:0];
      CFG_LOCK_FROM:     regs_q.lock_from     = val[CMD_W-1:0];
      CFG_LOCK_TO:       regs_q.lock_to       = val[CMD_W-1:0];
      CFG_REV_SLOW_TO:   regs_q.rev_slow_to   = val[CMD_W-1:0];
      CFG_CYCLE_TOP:     regs_q.cycle_top     = val[DUTY_W-1:0];
      CFG_OFF_ABOVE:     regs_q.off_above     = val[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input cfg_t c);
    write_reg(CFG_WIDTH_OFFSET, DW'(c.width_offset));
    write_reg(CFG_VALID_END, c.valid_end);
    write_reg(CFG_FWD_SLOW_FROM, c.fwd_slow_from);
    write_reg(CFG_LOCK_FROM, c.lock_from);
    write_reg(CFG_LOCK_TO, c.lock_to);
    write_reg(CFG_REV_SLOW_TO, c.rev_slow_to);
    write_reg(CFG_CYCLE_TOP, DW'(c.cycle_top));
    write_reg(CFG_OFF_ABOVE, DW'(c.off_above));
  endtask

  function automatic cfg_t band_set(input int ofs, input int ve, input int fs, input int lf,
                                    input int lt, input int rs, input int top, input int oa);
    cfg_t c;
    c.width_offset  = OFS_W'(ofs);
    c.valid_end     = CMD_W'(ve);
    c.fwd_slow_from = CMD_W'(fs);
    c.lock_from     = CMD_W'(lf);
    c.lock_to       = CMD_W'(lt);
    c.rev_slow_to   = CMD_W'(rs);
    c.cycle_top     = DUTY_W'(top);
    c.off_above     = DUTY_W'(oa);
    return c;
  endfunction

  function automatic cfg_t reset_regs();
    cfg_t c;
    c.width_offset  = RST_WIDTH_OFFSET;
    c.valid_end     = RST_VALID_END;
    c.fwd_slow_from = RST_FWD_SLOW_FROM;
    c.lock_from     = RST_LOCK_FROM;
    c.lock_to       = RST_LOCK_TO;
    c.rev_slow_to   = RST_REV_SLOW_TO;
    c.cycle_top     = RST_CYCLE_TOP;
    c.off_above     = RST_OFF_ABOVE;
    return c;
  endfunction

  // Mostly ordered, narrow bands so short pulses land in every zone
  function automatic cfg_t pick_regs();
    int fs, lf, lt, rs, ve, top;
    top = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8);
    if ($urandom_range(0, 4) == 0) begin
      return band_set($urandom_range(0, 12), $urandom_range(0, 120), $urandom_range(0, 120),
                      $urandom_range(0, 120), $urandom_range(0, 120), $urandom_range(0, 120),
                      top, $urandom_range(0, 63));
    end
    fs = $urandom_range(5, 30);
    lf = fs + $urandom_range(0, 20);
    lt = lf + $urandom_range(0, 20);
    rs = lt + $urandom_range(0, 20);
    ve = rs + $urandom_range(0, 30);
    return band_set($urandom_range(0, 12), ve, fs, lf, lt, rs, top,
                    $urandom_range(0, top + 1));
  endfunction

  task automatic push_pulse(input int width, input int lows);
    repeat (width) sample_queue.push_back(1'b1);
    repeat (lows) sample_queue.push_back(1'b0);
    queued_total += width + lows;
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || drive_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    int   rand_count;
    int   phase;
    int   target;
    int   width;
    int   lows;
    int   span;
    bit   bit_val;
    cfg_t c;

    regs_q    = reset_regs();
    width_cnt = '0;
    cmd_q     = '0;
    duty_q    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: low with nothing counted, then one pulse per zone, below and above the band
    load_regs(band_set(0, 30, 8, 12, 16, 20, 3, 1));
    push_pulse(0, 2);
    push_pulse(1, 1);
    push_pulse(2, 1);
    push_pulse(3, 5);
    push_pulse(4, 1);
    push_pulse(6, 5);
    push_pulse(7, 1);
    push_pulse(10, 1);
    wait_drained();

    // Default registers restored, full-width pulses
    load_regs(reset_regs());
    push_pulse($urandom_range(252, 580), 45);
    push_pulse(100, 3);
    wait_drained();

    // Long pulse into wide bands, duty counter runs through its widest wrap
    load_regs(band_set(0, 16383, 5, 150, 300, 450, 63, 0));
    push_pulse(200, 70);
    wait_drained();

    // Largest offset, nothing valid, short duty cycle with a top value of 1
    load_regs(band_set(4095, 0, 16383, 16383, 16383, 16383, 1, 63));
    push_pulse(30, 3);
    push_pulse(1, 4);
    wait_drained();

    rand_count = queued_total;
    phase      = 0;
    while (rand_count < ITEM_TOTAL) begin
      c = pick_regs();
      load_regs(c);
      if (phase == 1) want_hold = 1'b1;
      target = rand_count + $urandom_range(120, 220);
      span   = c.valid_end / 3 + c.width_offset + 4;
      if (span > 80) span = 80;
      while (rand_count < target) begin
        if ($urandom_range(0, 7) == 0) begin
          // noise: short random bit strings
          repeat ($urandom_range(1, 8)) begin
            bit_val = 1'($urandom_range(0, 1));
            sample_queue.push_back(bit_val);
            rand_count++;
          end
        end else begin
          width = $urandom_range(0, span);
          lows  = $urandom_range(1, (c.cycle_top > 18) ? 40 : 2 * c.cycle_top + 2);
          push_pulse(width, lows);
          rand_count += width + lows;
        end
      end
      wait_drained();
      phase++;
    end

    if (drive_due.size() != 0)
      report_fault($sformatf("%0d drive pairs never arrived", drive_due.size()));
    if (fault_count == 0) begin
      $display("rc_pulse_to_hbridge_drive test passed");
    end else begin
      $display("rc_pulse_to_hbridge_drive test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rcph_pkg.sv
design/rcph_decode.sv
design/rc_pulse_to_hbridge_drive.sv
bench/tb_rc_pulse_to_hbridge_drive.sv
